// ===== rtl/ptw_pkg.sv =====
// ptw_pkg: widths, constants, command/status structs and the index helper
// for the four-level page table walker; no dependencies
package ptw_pkg;

  localparam int ENTRY_W          = 64;
  localparam int VA_W             = 48;
  localparam int ADDR_IN_W        = 13;
  localparam int ROOT_W           = 4;
  localparam int IDX_W            = 9;
  localparam int ENTRIES_PER_PAGE = 512;
  localparam int PHYS_PAGES       = 16;
  localparam int TABLE_DEPTH      = PHYS_PAGES * ENTRIES_PER_PAGE;
  localparam int PAGE_W           = $clog2(PHYS_PAGES);
  localparam int ADDR_W           = $clog2(TABLE_DEPTH);
  localparam int PPN_LO           = 12;
  localparam int PPN_HI           = 51;
  localparam int PPN_W            = PPN_HI - PPN_LO + 1;
  localparam int PRESENT_BIT      = 0;
  localparam int LEVEL_W          = 2;
  localparam int L0_SHIFT         = 39;
  localparam int L1_SHIFT         = 30;
  localparam int L2_SHIFT         = 21;
  localparam int L3_SHIFT         = 12;

  localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_LAST = 2'd3;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_FAULT,
    RES_LEAF,
    RES_HOLD
  } res_src_t;

  typedef struct packed {
    logic     start;
    logic     read_root;
    logic     read_next;
    logic     mem_write;
    logic     load_out;
    logic     save_hold;
    res_src_t res_src;
  } ptw_cmd_t;

  typedef struct packed {
    logic root_bad;
    logic next_bad;
    logic absent;
    logic last_level;
    logic out_free;
  } ptw_stat_t;

  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                    input logic [LEVEL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[L0_SHIFT +: IDX_W];
      2'd1:    idx = va[L1_SHIFT +: IDX_W];
      2'd2:    idx = va[L2_SHIFT +: IDX_W];
      default: idx = va[L3_SHIFT +: IDX_W];
    endcase
    return idx;
  endfunction

endpackage

// ===== rtl/ptw_if.sv =====
// ptw_if: valid/ready channel interfaces for requests, responses and config
// depends on ptw_pkg
interface ptw_req_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [ptw_pkg::ADDR_IN_W-1:0]  entry_address;
  logic [ptw_pkg::ENTRY_W-1:0]    entry_value;
  logic [ptw_pkg::VA_W-1:0]       virtual_address;

  modport source (output valid, output opcode, output entry_address, output entry_value,
                  output virtual_address, input ready);
  modport sink (input valid, input opcode, input entry_address, input entry_value,
                input virtual_address, output ready);
endinterface

interface ptw_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ptw_pkg::ENTRY_W-1:0]  leaf_entry;
  logic                         fault;

  modport source (output valid, output leaf_entry, output fault, input ready);
  modport sink (input valid, input leaf_entry, input fault, output ready);
endinterface

interface ptw_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ptw_pkg::ROOT_W-1:0]  root_page;

  modport source (output valid, output root_page, input ready);
  modport sink (input valid, input root_page, output ready);
endinterface

// ===== rtl/ptw_ram.sv =====
// ptw_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ptw_datapath.sv =====
// ptw_datapath: root register, table memory, walk registers and result register
// depends on ptw_pkg and ptw_ram
module ptw_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ptw_pkg::ROOT_W-1:0]    cfg_root,
  input  logic [ptw_pkg::ADDR_IN_W-1:0] entry_address,
  input  logic [ptw_pkg::ENTRY_W-1:0]   entry_value,
  input  logic [ptw_pkg::VA_W-1:0]      virtual_address,
  input  ptw_pkg::ptw_cmd_t             cmd,
  output ptw_pkg::ptw_stat_t            stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [ptw_pkg::ENTRY_W-1:0]   out_leaf,
  output logic                          out_fault
);
  import ptw_pkg::*;

  logic [ROOT_W-1:0]  root_page;
  logic [VA_W-1:0]    va;
  logic [LEVEL_W-1:0] level;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] hold_leaf;
  logic               hold_fault;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [PPN_W-1:0]   root_ppn;
  logic [PPN_W-1:0]   next_ppn;
  logic [ENTRY_W-1:0] cand_leaf;
  logic               cand_fault;

  assign root_ppn = PPN_W'(root_page);
  assign next_ppn = rd_data[PPN_HI:PPN_LO];

  assign stat.root_bad   = root_ppn >= PPN_W'(PHYS_PAGES);
  assign stat.next_bad   = next_ppn >= PPN_W'(PHYS_PAGES);
  assign stat.absent     = !rd_data[PRESENT_BIT];
  assign stat.last_level = level == LEVEL_LAST;
  assign stat.out_free   = !out_valid || out_ready;

  // out of range writes still complete but leave the table alone
  assign wr_en   = cmd.mem_write && (32'(entry_address) < 32'(TABLE_DEPTH));
  assign wr_addr = ADDR_W'(entry_address);
  assign rd_en   = cmd.read_root || cmd.read_next;

  always_comb begin
    if (cmd.read_root) begin
      rd_addr = {root_ppn[PAGE_W-1:0], level_index(virtual_address, LEVEL_TOP)};
    end else begin
      rd_addr = {next_ppn[PAGE_W-1:0], level_index(va, level + 2'd1)};
    end
  end

  always_comb begin
    case (cmd.res_src)
      RES_ZERO: begin
        cand_leaf  = '0;
        cand_fault = 1'b0;
      end
      RES_FAULT: begin
        cand_leaf  = '0;
        cand_fault = 1'b1;
      end
      RES_LEAF: begin
        cand_leaf  = rd_data;
        cand_fault = 1'b0;
      end
      default: begin
        cand_leaf  = hold_leaf;
        cand_fault = hold_fault;
      end
    endcase
  end

  ptw_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(entry_value),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      root_page <= '0;
      level     <= LEVEL_TOP;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        root_page <= cfg_root;
      end
      if (cmd.start) begin
        level <= LEVEL_TOP;
      end else if (cmd.read_next) begin
        level <= level + 2'd1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      va <= virtual_address;
    end
    if (cmd.load_out) begin
      out_leaf  <= cand_leaf;
      out_fault <= cand_fault;
    end
    if (cmd.save_hold) begin
      hold_leaf  <= cand_leaf;
      hold_fault <= cand_fault;
    end
  end

endmodule

// ===== rtl/ptw_ctrl.sv =====
// ptw_ctrl: walk sequencer, issues commands to the datapath from its status
// depends on ptw_pkg
module ptw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_opcode,
  output logic               in_ready,
  input  ptw_pkg::ptw_stat_t stat,
  output ptw_pkg::ptw_cmd_t  cmd
);
  import ptw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   finish;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    finish     = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_WRITE) begin
            cmd.mem_write = 1'b1;
            cmd.res_src   = RES_ZERO;
            finish        = 1'b1;
          end else begin
            cmd.start = 1'b1;
            if (stat.root_bad) begin
              cmd.res_src = RES_FAULT;
              finish      = 1'b1;
            end else begin
              cmd.read_root = 1'b1;
              state_next    = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        if (stat.absent) begin
          cmd.res_src = RES_FAULT;
          finish      = 1'b1;
        end else if (stat.last_level) begin
          cmd.res_src = RES_LEAF;
          finish      = 1'b1;
        end else if (stat.next_bad) begin
          cmd.res_src = RES_FAULT;
          finish      = 1'b1;
        end else begin
          cmd.read_next = 1'b1;
        end
      end
      S_FINISH: begin
        cmd.res_src = RES_HOLD;
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // result goes straight out when the output register is free, else parks
    if (finish) begin
      if (stat.out_free) begin
        cmd.load_out = 1'b1;
        state_next   = S_IDLE;
      end else begin
        cmd.save_hold = 1'b1;
        state_next    = S_FINISH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/four_level_page_table_walker.sv =====
// four_level_page_table_walker: top level, joins the sequencer and the datapath
// depends on ptw_pkg, ptw_if, ptw_ctrl and ptw_datapath
//
//   port      role    moves
//   request   sink    one transaction: table write or address translation
//   response  source  one transaction per request: leaf entry and fault flag
//   cfg       sink    root page write, always ready
//
// a table write goes to the table memory as it is accepted; a translation makes one
// table memory read per level through the single read port, each feeding the next
// address. the result lands in an output register, so the next request is taken
// while a response waits. reset clears the root page and control only; the table
// holds no reset value.
module four_level_page_table_walker (
  input logic      clk,
  input logic      rst,
  ptw_req_if.sink  request,
  ptw_rsp_if.source response,
  ptw_cfg_if.sink  cfg
);
  import ptw_pkg::*;

  ptw_cmd_t  cmd;
  ptw_stat_t stat;
  logic      in_ready;

  assign request.ready = in_ready;
  assign cfg.ready     = 1'b1;

  ptw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_opcode(request.opcode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptw_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg.valid),
    .cfg_root       (cfg.root_page),
    .entry_address  (request.entry_address),
    .entry_value    (request.entry_value),
    .virtual_address(request.virtual_address),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (response.ready),
    .out_valid      (response.valid),
    .out_leaf       (response.leaf_entry),
    .out_fault      (response.fault)
  );

endmodule
